// ===== rtl/rlab_pkg.sv =====
// rlab_pkg: shared types, fixed-point formats and coefficient tables of the
// rgb / l-alpha-beta converter. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlab_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int CHANNEL_DIM = 3;
  localparam int COEF_BITS   = 14;
  localparam int LOG_BITS    = 20;
  localparam int EXP_BITS    = 24;
  localparam int COEF_W      = 18;
  localparam int EXP_STEPS   = 10;

  // forward rounding shift and inverse scaling shift
  localparam int FWD_SHIFT = COEF_BITS + LOG_BITS - FRAC_BITS;
  localparam int INV_SHIFT = COEF_BITS + FRAC_BITS - LOG_BITS;

  // pipeline depths, the inverse path is padded to the forward length
  localparam int FWD_DEPTH  = 8 + LOG_BITS;
  localparam int INV_CORE   = 18;
  localparam int PIPE_DEPTH = FWD_DEPTH;

  localparam logic signed [23:0] LOG10_2_Q24   = 24'sd5050445;
  localparam logic signed [26:0] LOG2_10_Q24   = 27'sd55732705;
  localparam logic [23:0]        LN2_Q24       = 24'd11629080;
  localparam logic signed [23:0] LOG_FLOOR_Q20 = -24'sd4194304;
  localparam logic signed [24:0] LOG_LIMIT_Q20 = 25'sd8388608;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t RGB2LMS [CHANNEL_DIM][CHANNEL_DIM] = '{
    '{18'sd6244, 18'sd9475, 18'sd659},
    '{18'sd3223, 18'sd11869, 18'sd1281},
    '{18'sd395, 18'sd2110, 18'sd13835}};
  localparam coef_t LMS2RGB [CHANNEL_DIM][CHANNEL_DIM] = '{
    '{18'sd73202, -18'sd58774, 18'sd1955},
    '{-18'sd19966, 18'sd39009, -18'sd2661},
    '{18'sd814, -18'sd3996, 18'sd19735}};
  localparam coef_t LMS2LAB [CHANNEL_DIM][CHANNEL_DIM] = '{
    '{18'sd9459, 18'sd9459, 18'sd9459},
    '{18'sd6689, 18'sd6689, -18'sd13377},
    '{18'sd11585, -18'sd11585, 18'sd0}};
  localparam coef_t LAB2LMS [CHANNEL_DIM][CHANNEL_DIM] = '{
    '{18'sd9459, 18'sd6689, 18'sd11585},
    '{18'sd9459, 18'sd6689, -18'sd11585},
    '{18'sd9459, -18'sd13377, 18'sd0}};

  // 2^(2^-(i+1)) in q24
  localparam logic [24:0] EXP_STEP [EXP_STEPS] = '{
    25'd23726566, 25'd19951585, 25'd18295684, 25'd17520007, 25'd17144589,
    25'd16959908, 25'd16868315, 25'd16822704, 25'd16799944, 25'd16788576};

  typedef struct packed {
    logic signed [15:0] third;
    logic signed [15:0] second;
    logic signed [15:0] first;
  } pix_t;

  typedef struct packed {
    logic valid;
    pix_t data;
  } pix_beat_t;

endpackage

`default_nettype wire

// ===== rtl/rlab_fwd_path.sv =====
// rlab_fwd_path: rgb to l-alpha-beta datapath, matrix, squaring log10, matrix.
// depends on rlab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlab_fwd_path (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire rlab_pkg::pix_t pix_i,
  output rlab_pkg::pix_t      res_o
);
  import rlab_pkg::*;

  localparam int SQ = LOG_BITS;

  logic signed [15:0] a [CHANNEL_DIM];
  logic signed [33:0] p1_q [CHANNEL_DIM][CHANNEL_DIM];
  logic signed [35:0] lms_q [CHANNEL_DIM];
  logic [30:0]        u_q [CHANNEL_DIM];
  logic [4:0]         lz [CHANNEL_DIM];
  logic               pos_q [SQ+3][CHANNEL_DIM];
  logic [4:0]         p_q [SQ+1][CHANNEL_DIM];
  logic [30:0]        sm_q [SQ+1][CHANNEL_DIM];
  logic [LOG_BITS-1:0] fr_q [SQ+1][CHANNEL_DIM];
  logic signed [49:0] l10_q [CHANNEL_DIM];
  logic signed [23:0] mid_q [CHANNEL_DIM];
  logic signed [41:0] p2_q [CHANNEL_DIM][CHANNEL_DIM];
  pix_t               res_q;

  assign a[0] = pix_i.first;
  assign a[1] = pix_i.second;
  assign a[2] = pix_i.third;

  // stage 1..4: products, sums, msb search, normalise
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CHANNEL_DIM; k++) begin
        for (int j = 0; j < CHANNEL_DIM; j++) begin
          p1_q[k][j] <= 34'(RGB2LMS[k][j]) * 34'(a[j]);
        end
        lms_q[k] <= 36'(p1_q[k][0]) + 36'(p1_q[k][1]) + 36'(p1_q[k][2]);
        pos_q[0][k] <= !lms_q[k][35] && (lms_q[k] != '0);
        u_q[k] <= lms_q[k][30:0];
        p_q[0][k] <= lz[k];
        pos_q[1][k] <= pos_q[0][k];
        sm_q[0][k] <= u_q[k] << (5'd30 - lz[k]);
        fr_q[0][k] <= '0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < CHANNEL_DIM; k++) begin
      lz[k] = '0;
      for (int b = 0; b < 31; b++) begin
        if (u_q[k][b]) lz[k] = 5'(b);
      end
    end
  end

  // one squaring step per stage gives one fraction bit of log2
  for (genvar s = 0; s < SQ; s++) begin : g_sq
    logic [61:0] sq [CHANNEL_DIM];
    always_comb begin
      for (int k = 0; k < CHANNEL_DIM; k++) begin
        sq[k] = 62'(sm_q[s][k]) * 62'(sm_q[s][k]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < CHANNEL_DIM; k++) begin
          p_q[s+1][k] <= p_q[s][k];
          pos_q[s+2][k] <= pos_q[s+1][k];
          if (sq[k][61]) begin
            sm_q[s+1][k] <= sq[k][61:31];
            fr_q[s+1][k] <= {fr_q[s][k][LOG_BITS-2:0], 1'b1};
          end else begin
            sm_q[s+1][k] <= sq[k][60:30];
            fr_q[s+1][k] <= {fr_q[s][k][LOG_BITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  logic signed [25:0] l2 [CHANNEL_DIM];
  logic signed [43:0] sum [CHANNEL_DIM];
  logic signed [43:0] shd [CHANNEL_DIM];
  logic signed [15:0] sat [CHANNEL_DIM];

  always_comb begin
    for (int k = 0; k < CHANNEL_DIM; k++) begin
      l2[k] = $signed({6'(p_q[SQ][k]) - 6'd14, fr_q[SQ][k]});
      sum[k] = 44'(p2_q[k][0]) + 44'(p2_q[k][1]) + 44'(p2_q[k][2])
             + (44'sd1 <<< (FWD_SHIFT - 1));
      shd[k] = sum[k] >>> FWD_SHIFT;
      if (shd[k] > 44'sd32767) sat[k] = 16'sd32767;
      else if (shd[k] < -44'sd32768) sat[k] = -16'sd32768;
      else sat[k] = shd[k][15:0];
    end
  end

  // scale to log10, lab matrix, round and saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CHANNEL_DIM; k++) begin
        l10_q[k] <= 50'(l2[k]) * 50'(LOG10_2_Q24);
        pos_q[SQ+2][k] <= pos_q[SQ+1][k];
        mid_q[k] <= pos_q[SQ+2][k] ? 24'(l10_q[k] >>> EXP_BITS) : LOG_FLOOR_Q20;
        for (int j = 0; j < CHANNEL_DIM; j++) begin
          p2_q[k][j] <= 42'(LMS2LAB[k][j]) * 42'(mid_q[j]);
        end
      end
      res_q.first  <= sat[0];
      res_q.second <= sat[1];
      res_q.third  <= sat[2];
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/rlab_inv_path.sv =====
// rlab_inv_path: l-alpha-beta to rgb datapath, matrix, stepwise 10^x, matrix
// and clamp, padded to the forward latency. depends on rlab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlab_inv_path (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire rlab_pkg::pix_t pix_i,
  output rlab_pkg::pix_t      res_o
);
  import rlab_pkg::*;

  localparam int PAD = PIPE_DEPTH - INV_CORE;

  logic signed [15:0] a [CHANNEL_DIM];
  logic signed [33:0] p1_q [CHANNEL_DIM][CHANNEL_DIM];
  logic signed [24:0] x_q [CHANNEL_DIM];
  logic signed [51:0] px_q [CHANNEL_DIM];
  logic [25:0]        m_q [EXP_STEPS+1][CHANNEL_DIM];
  logic [LOG_BITS-1:0] f_q [EXP_STEPS][CHANNEL_DIM];
  logic signed [5:0]  n_q [EXP_STEPS+2][CHANNEL_DIM];
  logic [35:0]        mr_q [CHANNEL_DIM];
  logic [25:0]        m2_q [CHANNEL_DIM];
  logic [41:0]        mid_q [CHANNEL_DIM];
  logic signed [39:0] pl_q [CHANNEL_DIM][CHANNEL_DIM];
  logic signed [39:0] ph_q [CHANNEL_DIM][CHANNEL_DIM];
  logic signed [61:0] pf_q [CHANNEL_DIM][CHANNEL_DIM];
  pix_t               pad_q [PAD];

  assign a[0] = pix_i.first;
  assign a[1] = pix_i.second;
  assign a[2] = pix_i.third;

  logic signed [35:0] s1 [CHANNEL_DIM];
  logic signed [35:0] sh1 [CHANNEL_DIM];
  logic signed [25:0] y [CHANNEL_DIM];

  always_comb begin
    for (int k = 0; k < CHANNEL_DIM; k++) begin
      s1[k] = 36'(p1_q[k][0]) + 36'(p1_q[k][1]) + 36'(p1_q[k][2]);
      sh1[k] = s1[k] >>> INV_SHIFT;
      y[k] = 26'(px_q[k] >>> EXP_BITS);
    end
  end

  // matrix, exponent clamp, scale to log2, first exponent step
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CHANNEL_DIM; k++) begin
        for (int j = 0; j < CHANNEL_DIM; j++) begin
          p1_q[k][j] <= 34'(LAB2LMS[k][j]) * 34'(a[j]);
        end
        if (sh1[k] > 36'(LOG_LIMIT_Q20)) x_q[k] <= LOG_LIMIT_Q20;
        else if (sh1[k] < -36'(LOG_LIMIT_Q20)) x_q[k] <= -LOG_LIMIT_Q20;
        else x_q[k] <= sh1[k][24:0];
        px_q[k] <= 52'(x_q[k]) * 52'(LOG2_10_Q24);
        n_q[0][k] <= y[k][25:LOG_BITS];
        f_q[0][k] <= y[k][LOG_BITS-1:0];
        m_q[0][k] <= y[k][LOG_BITS-1] ? 26'(EXP_STEP[0]) : 26'(1) << EXP_BITS;
      end
    end
  end

  // one table step per stage for the upper fraction bits
  for (genvar s = 1; s < EXP_STEPS; s++) begin : g_exp
    logic [50:0] pr [CHANNEL_DIM];
    always_comb begin
      for (int k = 0; k < CHANNEL_DIM; k++) begin
        pr[k] = 51'(m_q[s-1][k]) * 51'(EXP_STEP[s]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < CHANNEL_DIM; k++) begin
          n_q[s][k] <= n_q[s-1][k];
          f_q[s][k] <= f_q[s-1][k];
          m_q[s][k] <= f_q[s-1][k][LOG_BITS-1-s] ? pr[k][49:24] : m_q[s-1][k];
        end
      end
    end
  end

  logic [59:0]       lin [CHANNEL_DIM];
  logic signed [6:0] e [CHANNEL_DIM];
  logic [5:0]        ne [CHANNEL_DIM];

  always_comb begin
    for (int k = 0; k < CHANNEL_DIM; k++) begin
      lin[k] = 60'(mr_q[k]) * 60'(LN2_Q24);
      e[k] = 7'(n_q[EXP_STEPS+1][k]) - 7'sd10;
      ne[k] = 6'(-e[k]);
    end
  end

  // linear tail for the low fraction bits, then scale by 2^n into q14
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CHANNEL_DIM; k++) begin
        mr_q[k] <= 36'(m_q[EXP_STEPS-1][k]) * 36'(f_q[EXP_STEPS-1][k][9:0]);
        m_q[EXP_STEPS][k] <= m_q[EXP_STEPS-1][k];
        n_q[EXP_STEPS][k] <= n_q[EXP_STEPS-1][k];
        n_q[EXP_STEPS+1][k] <= n_q[EXP_STEPS][k];
        m2_q[k] <= m_q[EXP_STEPS][k] + 26'(lin[k] >> (LOG_BITS + EXP_BITS));
        if (!e[k][6]) mid_q[k] <= 42'(m2_q[k]) << e[k][4:0];
        else mid_q[k] <= 42'(m2_q[k]) >> ne[k];
      end
    end
  end

  logic signed [63:0] s2 [CHANNEL_DIM];
  logic [15:0]        rgb [CHANNEL_DIM];

  always_comb begin
    for (int k = 0; k < CHANNEL_DIM; k++) begin
      s2[k] = 64'(pf_q[k][0]) + 64'(pf_q[k][1]) + 64'(pf_q[k][2]);
      if (s2[k] > (64'sd255 <<< (2 * COEF_BITS))) rgb[k] = 16'd255;
      else if (s2[k] < 64'sd0) rgb[k] = 16'd0;
      else rgb[k] = {8'd0, s2[k][2*COEF_BITS+7:2*COEF_BITS]};
    end
  end

  // rgb matrix in two partial products over 21-bit halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CHANNEL_DIM; k++) begin
        for (int j = 0; j < CHANNEL_DIM; j++) begin
          pl_q[k][j] <= 40'(LMS2RGB[k][j]) * 40'($signed({1'b0, mid_q[j][20:0]}));
          ph_q[k][j] <= 40'(LMS2RGB[k][j]) * 40'($signed({1'b0, mid_q[j][41:21]}));
          pf_q[k][j] <= (62'(ph_q[k][j]) <<< 21) + 62'(pl_q[k][j]);
        end
      end
      pad_q[0].first  <= rgb[0];
      pad_q[0].second <= rgb[1];
      pad_q[0].third  <= rgb[2];
      for (int i = 1; i < PAD; i++) begin
        pad_q[i] <= pad_q[i-1];
      end
    end
  end

  assign res_o = pad_q[PAD-1];

endmodule

`default_nettype wire

// ===== rtl/rlab_out_skid.sv =====
// rlab_out_skid: output register with one skid entry; holds the pipeline when
// the skid entry is taken. depends on rlab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlab_out_skid (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rlab_pkg::pix_beat_t push_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              tready_i,
  output rlab_pkg::pix_t          data_o
);
  import rlab_pkg::*;

  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  pix_t out_q, out_d, skid_q, skid_d;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (push_i.valid) begin
      if (!out_vld_q || tready_i) begin
        out_vld_d = 1'b1;
        out_d     = push_i.data;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = push_i.data;
      end
    end else if (out_vld_q && tready_i) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/rgb_lalphabeta_converter_top.sv =====
// rgb_lalphabeta_converter_top: pixel converter between rgb and l-alpha-beta.
// depends on rlab_pkg, rlab_fwd_path, rlab_inv_path, rlab_out_skid.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata 48b: first, second, third
//   m_axis    out  m_axis_tvalid/tready      tdata 48b: first, second, third
//   cfg       in   cfg_valid_i/cfg_ready_o   cfg_data_i: direction
//
// one pixel per cycle while the skid entry is free; the pipeline depth is
// set by the forward path: matrix, 20 squaring stages of the log, lab matrix.
// the inverse path is padded to the same depth.
// rst_ni clears the valid bits and direction; no clearing pass.
// a stalled output fills the skid entry, after which the whole pipeline holds.
`timescale 1ns / 1ps
`default_nettype none

module rgb_lalphabeta_converter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // comp_first, comp_second, comp_third
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // res_first, res_second, res_third
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);
  import rlab_pkg::*;

  logic      dir_q;
  logic      en;
  logic      vld_q [PIPE_DEPTH];
  pix_t      pix_in, fwd_res, inv_res, out_data;
  pix_beat_t push;

  assign pix_in = s_axis_tdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_valid_i) begin
      dir_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < PIPE_DEPTH; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  rlab_fwd_path u_fwd (
    .clk_i (clk_i),
    .en_i  (en),
    .pix_i (pix_in),
    .res_o (fwd_res)
  );

  rlab_inv_path u_inv (
    .clk_i (clk_i),
    .en_i  (en),
    .pix_i (pix_in),
    .res_o (inv_res)
  );

  assign push.valid = en && vld_q[PIPE_DEPTH-1];
  assign push.data  = dir_q ? inv_res : fwd_res;

  rlab_out_skid u_skid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .ready_o  (en),
    .valid_o  (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .data_o   (out_data)
  );

  assign s_axis_tready = en;
  assign m_axis_tdata  = out_data;

  // a full skid entry means the output register holds a beat too
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> m_axis_tvalid) else $error("skid full with empty output");

  // a held pipeline keeps its last-stage valid bit
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q[PIPE_DEPTH-1])) else $error("pipeline moved while held");

  // inverse results are clamped rgb
  a_inv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && dir_q) |-> (m_axis_tdata[15:8] == 8'd0 &&
      m_axis_tdata[31:24] == 8'd0 && m_axis_tdata[47:40] == 8'd0))
    else $error("inverse result out of range");

endmodule

`default_nettype wire
